/* src/fca_pkg.sv */
// shared constants, codes and types of the file allocation table block
package fca_pkg;

   localparam int BLOCKS = 1024;
   localparam int ADDR_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int CNT_W  = $clog2(BLOCKS + 1);

   localparam logic [15:0] END_MARK  = 16'hFFFF;
   localparam logic [15:0] FREE_MARK = 16'h0000;
   localparam logic [15:0] BLOCKS_16 = 16'(BLOCKS);

   typedef enum logic [1:0] {
      OP_FORMAT = 2'd0,
      OP_ALLOC  = 2'd1,
      OP_FREE   = 2'd2,
      OP_NEXT   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_FREE   = 2'd1,
      ST_BAD_INDEX = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_MARK,
      S_LINK,
      S_WALK,
      S_FREE,
      S_READ,
      S_FETCH,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [15:0] result_block;
      logic [1:0]  status;
      logic [15:0] freed_count;
   } rsp_payload_type;

endpackage

/* src/fca_channels.sv */
// valid/ready channel interfaces for request and response items
interface fca_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] block_index;
   logic        link_previous;

   modport source (output valid, output operation, output block_index,
                   output link_previous, input ready);
   modport sink (input valid, input operation, input block_index,
                 input link_previous, output ready);
endinterface

interface fca_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] result_block;
   logic [1:0]  status;
   logic [15:0] freed_count;

   modport source (output valid, output result_block, output status,
                   output freed_count, input ready);
   modport sink (input valid, input result_block, input status,
                 input freed_count, output ready);
endinterface

/* src/fca_rsp_stage.sv */
// output register stage holding one response item until it is taken
module fca_rsp_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  fca_pkg::rsp_payload_type payload,
   output logic                     free,
   fca_rsp_if.source                rsp_if
);

   logic                     valid_ff, valid_in;
   fca_pkg::rsp_payload_type payload_ff;

   assign free     = !valid_ff || rsp_if.ready;
   assign valid_in = load || (valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && free) begin
         payload_ff <= payload;
      end
   end

   assign rsp_if.valid        = valid_ff;
   assign rsp_if.result_block = payload_ff.result_block;
   assign rsp_if.status       = payload_ff.status;
   assign rsp_if.freed_count  = payload_ff.freed_count;

endmodule

/* src/fat_chain_allocator.sv */
// file allocation table: format, allocate, free chain and read next over one table memory
//
//  channel | dir | handshake     | payload
//  req_if  | in  | valid / ready | operation, block_index, link_previous
//  rsp_if  | out | valid / ready | result_block, status, freed_count
//
// one item at a time through a sequencer around a table memory with separate read and write ports
// format clears the table; read next reads one entry; allocate scans for the lowest free index and marks it,
// then links it to the previous entry if asked; free chain reads and clears each entry of the chain in turn
// after reset a clearing pass over all BLOCKS entries runs before the first item is taken
// a finished response waits in the output register; the next item is taken meanwhile

module fat_chain_allocator (
   input  logic     clock,
   input  logic     reset,
   fca_req_if.sink  req_if,
   fca_rsp_if.source rsp_if
);

   fca_pkg::state_type state_ff, state_in;

   logic [fca_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                       fmt_ff, fmt_in;
   logic                       pend_valid_ff, pend_valid_in;
   logic [fca_pkg::ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [15:0]                idx_ff, idx_in;
   logic                       link_ff, link_in;
   logic [15:0]                blk_ff, blk_in;
   logic [15:0]                freed_ff, freed_in;
   logic [15:0]                result_ff, result_in;
   fca_pkg::status_type        status_ff, status_in;

   // table memory
   logic [15:0]                mem [fca_pkg::BLOCKS];
   logic                       wr_en, rd_en;
   logic [fca_pkg::ADDR_W-1:0] wr_addr, rd_addr;
   logic [15:0]                wr_data;
   logic [15:0]                rd_data_ff;

   logic                     accept;
   logic                     out_free;
   logic                     out_load;
   fca_pkg::rsp_payload_type out_payload;
   logic                     issue_ok;
   logic                     clear_last;
   logic                     req_bad;
   logic                     blk_stop;
   logic                     blk_bad;

   assign req_if.ready = (state_ff == fca_pkg::S_IDLE);
   assign accept       = req_if.valid && req_if.ready;

   assign issue_ok   = cnt_ff < fca_pkg::CNT_W'(fca_pkg::BLOCKS);
   assign clear_last = cnt_ff == fca_pkg::CNT_W'(fca_pkg::BLOCKS - 1);
   assign req_bad    = req_if.block_index >= fca_pkg::BLOCKS_16;
   assign blk_stop   = (blk_ff == fca_pkg::END_MARK) || (blk_ff == fca_pkg::FREE_MARK)
                       || (freed_ff >= fca_pkg::BLOCKS_16);
   assign blk_bad    = blk_ff >= fca_pkg::BLOCKS_16;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fca_pkg::S_CLEAR: begin
            if (clear_last) begin
               state_in = fmt_ff ? fca_pkg::S_DONE : fca_pkg::S_IDLE;
            end
         end
         fca_pkg::S_IDLE: begin
            if (accept) begin
               unique case (fca_pkg::op_type'(req_if.operation))
                  fca_pkg::OP_FORMAT: state_in = fca_pkg::S_CLEAR;
                  fca_pkg::OP_ALLOC:
                     state_in = (req_if.link_previous && req_bad) ? fca_pkg::S_DONE
                                                                   : fca_pkg::S_SCAN;
                  fca_pkg::OP_FREE:   state_in = fca_pkg::S_WALK;
                  fca_pkg::OP_NEXT:   state_in = req_bad ? fca_pkg::S_DONE : fca_pkg::S_READ;
                  default:            state_in = fca_pkg::S_IDLE;
               endcase
            end
         end
         fca_pkg::S_SCAN: begin
            if (pend_valid_ff && (rd_data_ff == fca_pkg::FREE_MARK)) begin
               state_in = fca_pkg::S_MARK;
            end else if (!pend_valid_ff && !issue_ok) begin
               state_in = fca_pkg::S_DONE;
            end
         end
         fca_pkg::S_MARK:  state_in = link_ff ? fca_pkg::S_LINK : fca_pkg::S_DONE;
         fca_pkg::S_LINK:  state_in = fca_pkg::S_DONE;
         fca_pkg::S_WALK:  state_in = (blk_stop || blk_bad) ? fca_pkg::S_DONE : fca_pkg::S_FREE;
         fca_pkg::S_FREE:  state_in = fca_pkg::S_WALK;
         fca_pkg::S_READ:  state_in = fca_pkg::S_FETCH;
         fca_pkg::S_FETCH: state_in = fca_pkg::S_DONE;
         fca_pkg::S_DONE: begin
            if (out_free) begin
               state_in = fca_pkg::S_IDLE;
            end
         end
         default: state_in = fca_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cnt_in        = cnt_ff;
      fmt_in        = fmt_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      idx_in        = idx_ff;
      link_in       = link_ff;
      blk_in        = blk_ff;
      freed_in      = freed_ff;
      result_in     = result_ff;
      status_in     = status_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = fca_pkg::FREE_MARK;
      rd_en         = 1'b0;
      rd_addr       = '0;
      out_load      = 1'b0;
      unique case (state_ff)
         fca_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[fca_pkg::ADDR_W-1:0];
            wr_data = (cnt_ff == '0) ? fca_pkg::END_MARK : fca_pkg::FREE_MARK;
            cnt_in  = cnt_ff + 1'b1;
         end
         fca_pkg::S_IDLE: begin
            if (accept) begin
               idx_in        = req_if.block_index;
               link_in       = req_if.link_previous;
               blk_in        = req_if.block_index;
               freed_in      = '0;
               result_in     = '0;
               status_in     = fca_pkg::ST_OK;
               fmt_in        = 1'b1;
               cnt_in        = '0;
               pend_valid_in = 1'b0;
               unique case (fca_pkg::op_type'(req_if.operation))
                  fca_pkg::OP_ALLOC: begin
                     cnt_in = fca_pkg::CNT_W'(1);
                     if (req_if.link_previous && req_bad) begin
                        status_in = fca_pkg::ST_BAD_INDEX;
                     end
                  end
                  fca_pkg::OP_NEXT: begin
                     if (req_bad) begin
                        status_in = fca_pkg::ST_BAD_INDEX;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         fca_pkg::S_SCAN: begin
            rd_en         = issue_ok;
            rd_addr       = cnt_ff[fca_pkg::ADDR_W-1:0];
            pend_valid_in = issue_ok;
            pend_addr_in  = cnt_ff[fca_pkg::ADDR_W-1:0];
            if (issue_ok) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (pend_valid_ff && (rd_data_ff == fca_pkg::FREE_MARK)) begin
               result_in     = 16'(pend_addr_ff);
               pend_valid_in = 1'b0;
            end else if (!pend_valid_ff && !issue_ok) begin
               status_in = fca_pkg::ST_NO_FREE;
            end
         end
         fca_pkg::S_MARK: begin
            wr_en   = 1'b1;
            wr_addr = result_ff[fca_pkg::ADDR_W-1:0];
            wr_data = fca_pkg::END_MARK;
         end
         fca_pkg::S_LINK: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[fca_pkg::ADDR_W-1:0];
            wr_data = result_ff;
         end
         fca_pkg::S_WALK: begin
            if (!blk_stop && blk_bad) begin
               status_in = fca_pkg::ST_BAD_INDEX;
            end
            rd_en   = !blk_stop && !blk_bad;
            rd_addr = blk_ff[fca_pkg::ADDR_W-1:0];
         end
         fca_pkg::S_FREE: begin
            wr_en    = 1'b1;
            wr_addr  = blk_ff[fca_pkg::ADDR_W-1:0];
            wr_data  = fca_pkg::FREE_MARK;
            freed_in = freed_ff + 1'b1;
            blk_in   = rd_data_ff;
         end
         fca_pkg::S_READ: begin
            rd_en   = 1'b1;
            rd_addr = idx_ff[fca_pkg::ADDR_W-1:0];
         end
         fca_pkg::S_FETCH: begin
            result_in = rd_data_ff;
         end
         fca_pkg::S_DONE: begin
            out_load = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fca_pkg::S_CLEAR;
         cnt_ff        <= '0;
         fmt_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         fmt_ff        <= fmt_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      idx_ff       <= idx_in;
      link_ff      <= link_in;
      blk_ff       <= blk_in;
      freed_ff     <= freed_in;
      result_ff    <= result_in;
      status_ff    <= status_in;
   end

   assign out_payload.result_block = result_ff;
   assign out_payload.status       = status_ff;
   assign out_payload.freed_count  = freed_ff;

   fca_rsp_stage u_rsp_stage (
      .clock   (clock),
      .reset   (reset),
      .load    (out_load),
      .payload (out_payload),
      .free    (out_free),
      .rsp_if  (rsp_if)
   );

endmodule

/* test/fat_chain_allocator_test.sv */
// self-checking testbench for the file allocation table block: directed table, then random
module fat_chain_allocator_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RUN_LIMIT     = 4_000_000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 2 * fca_pkg::BLOCKS + 64;
   localparam int PHASE_ITEMS   = 135;

   typedef struct packed {
      fca_pkg::op_type     op;
      logic [15:0]         idx;
      logic                link;
      logic                typed;
      logic [15:0]         want_block;
      fca_pkg::status_type want_status;
      logic [15:0]         want_freed;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fca_req_if req_ch ();
   fca_rsp_if rsp_ch ();

   fat_chain_allocator dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [15:0]              fat_shadow [fca_pkg::BLOCKS];
   fca_pkg::rsp_payload_type awaited_replies [$];
   logic [15:0]              chain_starts [$];
   logic [15:0]              chain_tail;
   logic [15:0]              read_cursor;
   int                       mismatch_count = 0;
   int                       req_idle_pct = 0;
   int                       rsp_stall_pct = 0;
   int                       hold_orders = 0;

   function automatic void clear_fat_shadow();
      int i;
      for (i = 0; i < fca_pkg::BLOCKS; i++)
         fat_shadow[i] = fca_pkg::FREE_MARK;
      fat_shadow[0] = fca_pkg::END_MARK;
   endfunction

   // updates the shadow table and returns the reply the block owes for this item
   function automatic fca_pkg::rsp_payload_type apply_fat_op(input fca_pkg::op_type op,
                                                             input logic [15:0] idx,
                                                             input logic link);
      fca_pkg::rsp_payload_type r;
      logic [15:0]              blk;
      logic [15:0]              nxt;
      int                       steps;
      int                       i;
      int                       found;
      r = '0;
      case (op)
         fca_pkg::OP_FORMAT: clear_fat_shadow();
         fca_pkg::OP_ALLOC: begin
            if (link && idx >= fca_pkg::BLOCKS_16) begin
               r.status = fca_pkg::ST_BAD_INDEX;
            end else begin
               found = 0;
               for (i = 1; i < fca_pkg::BLOCKS; i++) begin
                  if (found == 0 && fat_shadow[i] == fca_pkg::FREE_MARK)
                     found = i;
               end
               if (found == 0) begin
                  r.status = fca_pkg::ST_NO_FREE;
               end else begin
                  fat_shadow[found] = fca_pkg::END_MARK;
                  if (link)
                     fat_shadow[idx[fca_pkg::ADDR_W-1:0]] = 16'(found);
                  r.result_block = 16'(found);
               end
            end
         end
         fca_pkg::OP_FREE: begin
            blk = idx;
            steps = 0;
            while (blk != fca_pkg::END_MARK && blk != fca_pkg::FREE_MARK
                   && steps < fca_pkg::BLOCKS) begin
               if (blk >= fca_pkg::BLOCKS_16) begin
                  r.status = fca_pkg::ST_BAD_INDEX;
                  break;
               end
               nxt = fat_shadow[blk[fca_pkg::ADDR_W-1:0]];
               fat_shadow[blk[fca_pkg::ADDR_W-1:0]] = fca_pkg::FREE_MARK;
               r.freed_count = r.freed_count + 16'd1;
               steps++;
               blk = nxt;
            end
         end
         default: begin
            if (idx >= fca_pkg::BLOCKS_16)
               r.status = fca_pkg::ST_BAD_INDEX;
            else
               r.result_block = fat_shadow[idx[fca_pkg::ADDR_W-1:0]];
         end
      endcase
      return r;
   endfunction

   function automatic plan_row_type plan_row(input fca_pkg::op_type op, input logic [15:0] idx,
                                             input logic link, input logic typed,
                                             input logic [15:0] want_block,
                                             input fca_pkg::status_type want_status,
                                             input logic [15:0] want_freed);
      plan_row_type p;
      p.op = op;
      p.idx = idx;
      p.link = link;
      p.typed = typed;
      p.want_block = want_block;
      p.want_status = want_status;
      p.want_freed = want_freed;
      return p;
   endfunction

   // called at a rising edge; returns at the edge where the item is accepted
   task automatic offer_item(input fca_pkg::op_type op, input logic [15:0] idx,
                             input logic link, input logic typed,
                             input fca_pkg::rsp_payload_type want,
                             output fca_pkg::rsp_payload_type got);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.operation <= op;
      req_ch.block_index <= idx;
      req_ch.link_previous <= link;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      got = apply_fat_op(op, idx, link);
      awaited_replies.push_back(typed ? want : got);
   endtask

   task automatic wait_for_replies();
      req_ch.valid <= 1'b0;
      while (awaited_replies.size() != 0)
         @(posedge clock);
   endtask

   // mostly well-formed chain traffic: grow a chain, walk it, free it by its head
   task automatic offer_random_item();
      fca_pkg::op_type          op;
      logic [15:0]              idx;
      logic                     link;
      int                       pick;
      int                       sub;
      int                       k;
      fca_pkg::rsp_payload_type got;
      pick = $urandom_range(99);
      sub = $urandom_range(99);
      link = 1'($urandom_range(1));
      if (pick < 2) begin
         op = fca_pkg::OP_FORMAT;
         idx = 16'($urandom);
         offer_item(op, idx, link, 1'b0, '0, got);
         chain_starts.delete();
         chain_tail = fca_pkg::FREE_MARK;
      end else if (pick < 40) begin
         op = fca_pkg::OP_ALLOC;
         if (sub < 65 && chain_tail != fca_pkg::FREE_MARK) begin
            link = 1'b1;
            idx = chain_tail;
         end else if (sub < 85) begin
            link = 1'b0;
            idx = 16'($urandom);
         end else if (sub < 95) begin
            link = 1'b1;
            idx = 16'($urandom_range(fca_pkg::BLOCKS - 1));
         end else begin
            link = 1'b1;
            idx = 16'($urandom);
         end
         offer_item(op, idx, link, 1'b0, '0, got);
         if (got.status == fca_pkg::ST_OK) begin
            if (!link)
               chain_starts.push_back(got.result_block);
            chain_tail = got.result_block;
         end
      end else if (pick < 65) begin
         op = fca_pkg::OP_FREE;
         if (sub < 70 && chain_starts.size() != 0) begin
            k = $urandom_range(chain_starts.size() - 1);
            idx = chain_starts[k];
            chain_starts.delete(k);
         end else if (sub < 85) begin
            idx = 16'($urandom_range(fca_pkg::BLOCKS - 1));
         end else begin
            idx = 16'($urandom);
         end
         offer_item(op, idx, link, 1'b0, '0, got);
      end else begin
         op = fca_pkg::OP_NEXT;
         if (sub < 50)
            idx = read_cursor;
         else if (sub < 90)
            idx = 16'($urandom_range(fca_pkg::BLOCKS - 1));
         else
            idx = 16'($urandom);
         offer_item(op, idx, link, 1'b0, '0, got);
         if (got.status == fca_pkg::ST_OK && got.result_block != fca_pkg::END_MARK
             && got.result_block != fca_pkg::FREE_MARK)
            read_cursor = got.result_block;
         else if (chain_starts.size() != 0)
            read_cursor = chain_starts[$urandom_range(chain_starts.size() - 1)];
         else
            read_cursor = 16'($urandom_range(fca_pkg::BLOCKS - 1));
      end
   endtask

   initial begin : stimulus
      plan_row_type             plan [$];
      fca_pkg::rsp_payload_type want;
      fca_pkg::rsp_payload_type got;
      int                       n;
      int                       phase;
      req_ch.valid <= 1'b0;
      req_ch.operation <= fca_pkg::OP_FORMAT;
      req_ch.block_index <= '0;
      req_ch.link_previous <= 1'b0;
      clear_fat_shadow();
      chain_tail = fca_pkg::FREE_MARK;
      read_cursor = 16'd1;

      // extremes, range errors, links to block zero and to an unused entry, self link
      plan.push_back(plan_row(fca_pkg::OP_NEXT, 16'd0, 1'b0, 1'b1,
                              fca_pkg::END_MARK, fca_pkg::ST_OK, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_NEXT, 16'd1023, 1'b1, 1'b1,
                              16'd0, fca_pkg::ST_OK, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_NEXT, 16'd1024, 1'b0, 1'b1,
                              16'd0, fca_pkg::ST_BAD_INDEX, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_NEXT, 16'hFFFF, 1'b1, 1'b1,
                              16'd0, fca_pkg::ST_BAD_INDEX, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_ALLOC, 16'hFFFF, 1'b0, 1'b1,
                              16'd1, fca_pkg::ST_OK, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_ALLOC, 16'd1, 1'b1, 1'b1,
                              16'd2, fca_pkg::ST_OK, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_ALLOC, 16'd2, 1'b1, 1'b1,
                              16'd3, fca_pkg::ST_OK, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_NEXT, 16'd1, 1'b0, 1'b1,
                              16'd2, fca_pkg::ST_OK, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_ALLOC, 16'd1024, 1'b1, 1'b1,
                              16'd0, fca_pkg::ST_BAD_INDEX, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_ALLOC, 16'hFFFF, 1'b1, 1'b1,
                              16'd0, fca_pkg::ST_BAD_INDEX, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_ALLOC, 16'd0, 1'b1, 1'b1,
                              16'd4, fca_pkg::ST_OK, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_NEXT, 16'd0, 1'b0, 1'b1,
                              16'd4, fca_pkg::ST_OK, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_ALLOC, 16'd1000, 1'b1, 1'b1,
                              16'd5, fca_pkg::ST_OK, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_FREE, 16'd0, 1'b1, 1'b1,
                              16'd0, fca_pkg::ST_OK, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_FREE, 16'hFFFF, 1'b0, 1'b1,
                              16'd0, fca_pkg::ST_OK, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_FREE, 16'd1024, 1'b0, 1'b1,
                              16'd0, fca_pkg::ST_BAD_INDEX, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_FREE, 16'd1, 1'b0, 1'b1,
                              16'd0, fca_pkg::ST_OK, 16'd3));
      plan.push_back(plan_row(fca_pkg::OP_FREE, 16'd1000, 1'b0, 1'b1,
                              16'd0, fca_pkg::ST_OK, 16'd2));
      plan.push_back(plan_row(fca_pkg::OP_ALLOC, 16'd0, 1'b0, 1'b0,
                              16'd0, fca_pkg::ST_OK, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_ALLOC, 16'd1, 1'b1, 1'b0,
                              16'd0, fca_pkg::ST_OK, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_FREE, 16'd2, 1'b0, 1'b0,
                              16'd0, fca_pkg::ST_OK, 16'd0));
      // the freed block comes back and is linked to itself
      plan.push_back(plan_row(fca_pkg::OP_ALLOC, 16'd2, 1'b1, 1'b0,
                              16'd0, fca_pkg::ST_OK, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_FREE, 16'd1, 1'b0, 1'b0,
                              16'd0, fca_pkg::ST_OK, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_FORMAT, 16'hFFFF, 1'b1, 1'b1,
                              16'd0, fca_pkg::ST_OK, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_NEXT, 16'd0, 1'b0, 1'b1,
                              fca_pkg::END_MARK, fca_pkg::ST_OK, 16'd0));
      plan.push_back(plan_row(fca_pkg::OP_NEXT, 16'd4, 1'b0, 1'b1,
                              16'd0, fca_pkg::ST_OK, 16'd0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         want.result_block = plan[i].want_block;
         want.status = plan[i].want_status;
         want.freed_count = plan[i].want_freed;
         offer_item(plan[i].op, plan[i].idx, plan[i].link, plan[i].typed, want, got);
      end
      wait_for_replies();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 82; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 82; end
            default: begin req_idle_pct = 23; rsp_stall_pct = 23; end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++)
            offer_random_item();
         if (phase == 0) begin
            // receiver holds off while reads keep coming, so the input backs up
            hold_orders++;
            for (n = 0; n < 12; n++)
               offer_item(fca_pkg::OP_NEXT, 16'($urandom_range(fca_pkg::BLOCKS - 1)),
                          1'($urandom_range(1)), 1'b0, '0, got);
         end
         wait_for_replies();
      end

      wait_for_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : reply_pacing
      int hold_left;
      int hold_served;
      hold_left = 0;
      hold_served = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_orders) begin
            hold_served = hold_orders;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : reply_check
      fca_pkg::rsp_payload_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (awaited_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected reply item: block %0d status %0d freed %0d",
                        rsp_ch.result_block, rsp_ch.status, rsp_ch.freed_count);
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_ch.result_block !== want.result_block || rsp_ch.status !== want.status
                || rsp_ch.freed_count !== want.freed_count) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("reply mismatch: expected block %0d status %0d freed %0d, %s %0d %0d %0d",
                           want.result_block, want.status, want.freed_count, "got",
                           rsp_ch.result_block, rsp_ch.status, rsp_ch.freed_count);
            end
         end
      end
   end

   initial begin : watchdog
      repeat (RUN_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* sim.f */
src/fca_pkg.sv
src/fca_channels.sv
src/fca_rsp_stage.sv
src/fat_chain_allocator.sv
test/fat_chain_allocator_test.sv
